FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL that checks itself, included by the scheduler.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/srtf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srtf_pkg;

  // Fixed widths of the channel fields.
  localparam int TIME_PORT_W = 16;
  localparam int SLOT_PORT_W = 4;

  // Command codes on the input channel.
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Status codes on the result channel.
  typedef enum logic [2:0] {
    ST_LOADED    = 3'd0,
    ST_RAN       = 3'd1,
    ST_IDLE_TICK = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_CLEARED   = 3'd4
  } status_t;

  // Control from the sequencer to the selection unit.
  typedef struct packed {
    logic start;  // forget the previous pick before a new scan
    logic valid;  // table read data is valid this cycle
  } pick_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/srtf_table.sv
`timescale 1ns / 1ps
`default_nettype none

module srtf_table #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 48
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/srtf_pick.sv
`timescale 1ns / 1ps
`default_nettype none

module srtf_pick
  import srtf_pkg::*;
#(
  parameter int SLOT_W    = 4,
  parameter int TIME_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pick_ctrl_t           ctrl,
  input  wire logic [SLOT_W-1:0]    slot,
  input  wire logic [TIME_BITS-1:0] arrival,
  input  wire logic [TIME_BITS-1:0] burst,
  input  wire logic [TIME_BITS-1:0] remaining,
  input  wire logic [TIME_BITS-1:0] cur_tick,
  output logic                      found,
  output logic [SLOT_W-1:0]         best_slot,
  output logic [TIME_BITS-1:0]      best_arrival,
  output logic [TIME_BITS-1:0]      best_burst,
  output logic [TIME_BITS-1:0]      best_remaining
);

  logic better;

  // An entry wins if it has arrived, has work left and is strictly shorter,
  // so that ties stay with the lower slot seen first.
  assign better = ctrl.valid && (arrival <= cur_tick) && (remaining != '0) &&
                  (!found || (remaining < best_remaining));

  always_ff @(posedge clk) begin
    if (rst || ctrl.start) begin
      found <= 1'b0;
    end else if (better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_slot      <= slot;
      best_arrival   <= arrival;
      best_burst     <= burst;
      best_remaining <= remaining;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/srtf_preemptive_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   cmd, arrival_time, burst_time
// result    out        out_valid/out_stall status, job_slot, job_finished,
//                                          completion_time, waiting_time,
//                                          turnaround_time, all_done
//
// A load or clear is staged at the transfer and registered from the result state;
// a tick first passes the scan, drain and update states (update alone if empty):
// the table is scanned one entry per cycle through its single read port, and the
// pick is written back. The input stalls until the result is registered.
// Synchronous reset clears the counters and clock; the table needs no clearing.
// A waiting result does not stall the input; the next one waits in the sequencer.

module srtf_preemptive_scheduler
  import srtf_pkg::*;
#(
  parameter int MAX_JOBS  = 16,
  parameter int TIME_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             cmd,
  input  wire logic [TIME_PORT_W-1:0] arrival_time,
  input  wire logic [TIME_PORT_W-1:0] burst_time,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [2:0]                  status,
  output logic [SLOT_PORT_W-1:0]      job_slot,
  output logic                        job_finished,
  output logic [TIME_PORT_W-1:0]      completion_time,
  output logic [TIME_PORT_W-1:0]      waiting_time,
  output logic [TIME_PORT_W-1:0]      turnaround_time,
  output logic                        all_done
);

  localparam int SLOT_W  = $clog2(MAX_JOBS);
  localparam int CNT_W   = $clog2(MAX_JOBS + 1);
  localparam int ENTRY_W = 3 * TIME_BITS;
  localparam int TWIDE_W = (TIME_BITS > TIME_PORT_W) ? TIME_BITS : TIME_PORT_W;
  localparam int SWIDE_W = (SLOT_W > SLOT_PORT_W) ? SLOT_W : SLOT_PORT_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_UPDATE = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]     jobs_loaded;
  logic [CNT_W-1:0]     jobs_completed;
  logic [TIME_BITS-1:0] current_tick;
  logic [CNT_W-1:0]     scan_idx;

  logic                 accept;
  cmd_t                 cmd_in;
  logic [TWIDE_W-1:0]   arr_wide;
  logic [TWIDE_W-1:0]   bur_wide;
  logic [TIME_BITS-1:0] arr_in;
  logic [TIME_BITS-1:0] bur_in;
  logic                 load_ok;

  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_addr;
  logic [ENTRY_W-1:0]   wr_data;
  logic                 rd_en;
  logic [SLOT_W-1:0]    rd_addr;
  logic [ENTRY_W-1:0]   rd_data;
  logic                 rd_valid;
  logic [SLOT_W-1:0]    rd_slot;

  pick_ctrl_t           pick_ctrl;
  logic                 found;
  logic [SLOT_W-1:0]    best_slot;
  logic [TIME_BITS-1:0] best_arrival;
  logic [TIME_BITS-1:0] best_burst;
  logic [TIME_BITS-1:0] best_remaining;

  logic [TIME_BITS-1:0] rem_dec;
  logic [TIME_BITS-1:0] comp_val;
  logic [TIME_BITS-1:0] tat_val;
  logic [TIME_BITS-1:0] wait_val;

  status_t              res_status;
  logic [SLOT_W-1:0]    res_slot;
  logic                 res_fin;
  logic [TIME_BITS-1:0] res_comp;
  logic [TIME_BITS-1:0] res_tat;
  logic [TIME_BITS-1:0] res_burst;

  logic                 out_free;
  logic [TWIDE_W-1:0]   comp_wide;
  logic [TWIDE_W-1:0]   wait_wide;
  logic [TWIDE_W-1:0]   tat_wide;
  logic [SWIDE_W-1:0]   slot_wide;

  // Input transfer and field conditioning to the internal time width.
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cmd_in   = cmd_t'(cmd);
  assign arr_wide = TWIDE_W'(arrival_time);
  assign bur_wide = TWIDE_W'(burst_time);
  assign arr_in   = arr_wide[TIME_BITS-1:0];
  assign bur_in   = bur_wide[TIME_BITS-1:0];
  assign load_ok  = (bur_in != '0) && (jobs_loaded < CNT_W'(MAX_JOBS));

  // Table writes: a new job on load, the decremented entry after a tick.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = jobs_loaded[SLOT_W-1:0];
    wr_data = {arr_in, bur_in, bur_in};
    if (accept && (cmd_in == CMD_LOAD) && load_ok) begin
      wr_en = 1'b1;
    end else if ((state == S_UPDATE) && found) begin
      wr_en   = 1'b1;
      wr_addr = best_slot;
      wr_data = {best_arrival, best_burst, rem_dec};
    end
  end

  // Table reads during the scan, one slot per cycle.
  assign rd_en   = (state == S_SCAN);
  assign rd_addr = scan_idx[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= rd_addr;
  end

  srtf_table #(
    .DEPTH  (MAX_JOBS),
    .ADDR_W (SLOT_W),
    .DATA_W (ENTRY_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign pick_ctrl.start = accept && (cmd_in == CMD_TICK);
  assign pick_ctrl.valid = rd_valid;

  srtf_pick #(
    .SLOT_W    (SLOT_W),
    .TIME_BITS (TIME_BITS)
  ) u_pick (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (pick_ctrl),
    .slot           (rd_slot),
    .arrival        (rd_data[3*TIME_BITS-1:2*TIME_BITS]),
    .burst          (rd_data[2*TIME_BITS-1:TIME_BITS]),
    .remaining      (rd_data[TIME_BITS-1:0]),
    .cur_tick       (current_tick),
    .found          (found),
    .best_slot      (best_slot),
    .best_arrival   (best_arrival),
    .best_burst     (best_burst),
    .best_remaining (best_remaining)
  );

  // Completion figures for the picked job, with saturation and flooring.
  assign rem_dec  = best_remaining - TIME_BITS'(1);
  assign comp_val = (current_tick != TIME_MAX) ? current_tick + TIME_BITS'(1) : TIME_MAX;
  assign tat_val  = (comp_val > best_arrival) ? comp_val - best_arrival : '0;
  assign wait_val = (res_tat > res_burst) ? res_tat - res_burst : '0;

  // Sequencer and architectural counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      jobs_loaded    <= '0;
      jobs_completed <= '0;
      current_tick   <= '0;
      scan_idx       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd_in)
              CMD_LOAD: begin
                if (load_ok) begin
                  jobs_loaded <= jobs_loaded + CNT_W'(1);
                end
                state <= S_RESULT;
              end
              CMD_TICK: begin
                scan_idx <= '0;
                state    <= (jobs_loaded == '0) ? S_UPDATE : S_SCAN;
              end
              CMD_CLEAR: begin
                jobs_loaded    <= '0;
                jobs_completed <= '0;
                current_tick   <= '0;
                state          <= S_RESULT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + CNT_W'(1);
          if (scan_idx + CNT_W'(1) == jobs_loaded) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (found && (rem_dec == '0)) begin
            jobs_completed <= jobs_completed + CNT_W'(1);
          end
          if (current_tick != TIME_MAX) begin
            current_tick <= current_tick + TIME_BITS'(1);
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result staging, filled on the cycle the outcome is known.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_slot  <= jobs_loaded[SLOT_W-1:0];
      res_fin   <= 1'b0;
      res_comp  <= '0;
      res_tat   <= '0;
      res_burst <= '0;
      if (cmd_in == CMD_CLEAR) begin
        res_status <= ST_CLEARED;
        res_slot   <= '0;
      end else if (load_ok) begin
        res_status <= ST_LOADED;
      end else begin
        res_status <= ST_REJECTED;
        res_slot   <= '0;
      end
    end else if (state == S_UPDATE) begin
      res_fin   <= 1'b0;
      res_comp  <= '0;
      res_tat   <= '0;
      res_burst <= '0;
      if (found) begin
        res_status <= ST_RAN;
        res_slot   <= best_slot;
        if (rem_dec == '0) begin
          res_fin   <= 1'b1;
          res_comp  <= comp_val;
          res_tat   <= tat_val;
          res_burst <= best_burst;
        end
      end else begin
        res_status <= ST_IDLE_TICK;
        res_slot   <= '0;
      end
    end
  end

  // Output register.
  assign out_free  = !out_valid || !out_stall;
  assign comp_wide = TWIDE_W'(res_comp);
  assign wait_wide = TWIDE_W'(wait_val);
  assign tat_wide  = TWIDE_W'(res_tat);
  assign slot_wide = SWIDE_W'(res_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_RESULT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESULT) && out_free) begin
      status          <= res_status;
      job_slot        <= slot_wide[SLOT_PORT_W-1:0];
      job_finished    <= res_fin;
      completion_time <= comp_wide[TIME_PORT_W-1:0];
      waiting_time    <= wait_wide[TIME_PORT_W-1:0];
      turnaround_time <= tat_wide[TIME_PORT_W-1:0];
      all_done        <= (jobs_completed == jobs_loaded);
    end
  end

  // Checks on the design's own bookkeeping.
  `include "assert_macros.svh"

  `ASSERT_IMPL(a_completed_le_loaded, 1'b1, jobs_completed <= jobs_loaded)
  `ASSERT_IMPL(a_no_write_in_scan, (state == S_SCAN) || (state == S_DRAIN), !wr_en)
  `ASSERT_IMPL(a_pick_in_table, (state == S_UPDATE) && found, CNT_W'(best_slot) < jobs_loaded)
  `ASSERT_NEXT(a_finish_is_run, (state == S_RESULT) && out_free && res_fin,
               out_valid && (status == ST_RAN))

endmodule

`default_nettype wire
